/* rtl/skfa_pkg.sv */
package skfa_pkg;

   // Field widths fixed by the number formats.
   localparam int NOISE_W = 32;   // q, r and p, unsigned Q8.24
   localparam int GAIN_W  = 24;   // gain, unsigned Q0.24
   localparam int FACT_W  = 25;   // second multiplier operand
   localparam int PROD_W  = NOISE_W + FACT_W;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 2;

   typedef logic [NOISE_W-1:0] noise_type;
   typedef logic [GAIN_W-1:0]  gain_type;
   typedef logic [FACT_W-1:0]  factor_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [OP_W-1:0]    op_type;
   typedef logic [CSR_W-1:0]   csr_index_type;

   // Operation codes carried in the request tuser.
   localparam op_type OP_UPDATE = 2'd0;
   localparam op_type OP_ADAPT  = 2'd1;
   localparam op_type OP_REINIT = 2'd2;

   // Configuration register indexes.
   localparam csr_index_type CSR_Q_INIT = 2'd0;
   localparam csr_index_type CSR_R_INIT = 2'd1;

   // Reset values of the configuration registers.
   localparam noise_type Q_RESET = 32'd167772;
   localparam noise_type R_RESET = 32'd1677722;

   // Fixed-point constants.
   localparam int         ONE_Q16     = 65536;
   localparam factor_type GAIN_ONE    = 25'd16777216;
   localparam gain_type   GAIN_MAX    = 24'hFFFFFF;
   localparam int         HALF_Q24    = 8388608;
   localparam factor_type UP_FACTOR   = 25'd18454938;
   localparam factor_type DOWN_FACTOR = 25'd15099494;
   localparam noise_type  NOISE_FLOOR = 32'd17;

   // One quotient bit per divider step.
   localparam int DIV_STEPS = GAIN_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Round a Q8.24 by Q1.24 product back to Q8.24, saturate, then floor.
   function automatic noise_type scale_noise(input prod_type prod);
      logic [PROD_W:0]           rounded;
      logic [PROD_W-GAIN_W:0]    value;
      noise_type                 result;
      rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(HALF_Q24);
      value   = rounded[PROD_W:GAIN_W];
      if (value[PROD_W-GAIN_W:NOISE_W] != '0) begin
         result = '1;
      end else if (value[NOISE_W-1:0] < NOISE_FLOOR) begin
         result = NOISE_FLOOR;
      end else begin
         result = value[NOISE_W-1:0];
      end
      return result;
   endfunction

endpackage

/* rtl/scalar_kalman_filter_adaptive.sv */
// One-dimensional Kalman filter with adaptive noise, in fixed point. Each request word
// carries an operation in tuser (0 measurement update, 1 noise adapt, 2 reinitialize,
// 3 no change) and a signed Q16.16 sample in tdata; each request yields exactly one
// response word with the estimate, the gain and the current q and r. The block takes
// one request at a time. An update forms p+q and the denominator, then runs the
// restoring divider that produces one gain bit per cycle, then uses the single
// shared 32x25 multiplier (two partial products for the correction, one for the new
// covariance) and finally loads the response register. When p+q+r is zero or r is
// zero the divider is skipped. An adapt item uses the shared multiplier twice, once
// for q and once for r; reinitialize and the unused code go straight to loading
// the response register. A new request is accepted while the previous response
// still waits; the response register holds one finished word, and a finished item
// waits for it to drain before the block is ready again. Configuration writes are
// always ready and should only be issued while the block is idle.
module scalar_kalman_filter_adaptive #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request: tdata = sample_value; tuser = operation.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]        req_tdata,
   input  skfa_pkg::op_type                       req_tuser,
   // Response: tdata = estimate, gain, process_noise, measure_noise.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((DATA_WIDTH+88+7)/8)*8-1:0]     rsp_tdata,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  skfa_pkg::csr_index_type                csr_index,
   input  skfa_pkg::noise_type                    csr_data
);
   import skfa_pkg::*;

   localparam int RSP_W = ((DATA_WIDTH + 88 + 7) / 8) * 8;
   localparam int MAG_W = DATA_WIDTH + 1;
   localparam int EXT_W = (MAG_W > GAIN_W) ? MAG_W : GAIN_W + 1;
   localparam int ACC_W = EXT_W + 1;
   localparam int SUM_W = DATA_WIDTH + 3;
   localparam int CMP_W = DATA_WIDTH + 18;

   localparam logic signed [CMP_W-1:0] THRESH_POS = CMP_W'(ONE_Q16);
   localparam logic signed [CMP_W-1:0] THRESH_NEG = -THRESH_POS;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PREP   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_MUL_LO = 4'd3;
   localparam logic [3:0] S_MUL_HI = 4'd4;
   localparam logic [3:0] S_MUL_P  = 4'd5;
   localparam logic [3:0] S_P_WR   = 4'd6;
   localparam logic [3:0] S_A_Q    = 4'd7;
   localparam logic [3:0] S_A_R    = 4'd8;
   localparam logic [3:0] S_A_WR   = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic [3:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   noise_type                     cfg_q_ff, cfg_q_in;
   noise_type                     cfg_r_ff, cfg_r_in;
   logic signed [DATA_WIDTH-1:0]  estimate_ff, estimate_in;
   noise_type                     cov_ff, cov_in;
   noise_type                     q_ff, q_in;
   noise_type                     r_ff, r_in;
   gain_type                      gain_ff, gain_in;
   logic signed [DATA_WIDTH-1:0]  sample_ff, sample_in;
   noise_type                     pp_ff, pp_in;
   logic [NOISE_W:0]              den_ff, den_in;
   logic [NOISE_W:0]              rem_ff, rem_in;
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [GAIN_W:0]               corr_ff, corr_in;
   prod_type                      mul_ff, mul_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;

   noise_type                     mul_a;
   factor_type                    mul_b;
   logic [NOISE_W:0]              pp_sum;
   noise_type                     pp_sat;
   logic [NOISE_W:0]              den_sum;
   logic [DATA_WIDTH:0]           diff;
   logic [DATA_WIDTH:0]           diff_mag;
   logic [NOISE_W+1:0]            rem_dbl;
   logic [NOISE_W+1:0]            rem_sub;
   logic                          rem_ge;
   logic [EXT_W-1:0]              mag_ext;
   logic [2*GAIN_W:0]             lo_round;
   logic [ACC_W-1:0]              mag_acc;
   logic signed [SUM_W-1:0]       est_ext;
   logic signed [SUM_W-1:0]       mag_s;
   logic signed [SUM_W-1:0]       est_sum;
   logic                          est_over;
   logic [DATA_WIDTH-1:0]         est_sat;
   logic [PROD_W:0]               p_round;
   logic signed [CMP_W-1:0]       sample_cmp;
   logic                          big_err;

   // Prediction and denominator.
   assign pp_sum  = {1'b0, cov_ff} + {1'b0, q_ff};
   assign pp_sat  = pp_sum[NOISE_W] ? '1 : pp_sum[NOISE_W-1:0];
   assign den_sum = {1'b0, pp_sat} + {1'b0, r_ff};

   // Innovation sign and magnitude.
   assign diff     = {sample_ff[DATA_WIDTH-1], sample_ff}
                   - {estimate_ff[DATA_WIDTH-1], estimate_ff};
   assign diff_mag = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;

   // One restoring divider step.
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, den_ff};
   assign rem_ge  = (rem_dbl >= {1'b0, den_ff});

   // Correction assembled from the two partial products.
   assign mag_ext  = EXT_W'(mag_ff);
   assign lo_round = (2*GAIN_W + 1)'(mul_ff[2*GAIN_W-1:0]) + (2*GAIN_W + 1)'(HALF_Q24);
   assign mag_acc  = ACC_W'(mul_ff[EXT_W-1:0]) + ACC_W'(corr_ff);

   // Estimate update with saturation to the signed sample range.
   assign est_ext  = SUM_W'(estimate_ff);
   assign mag_s    = $signed(SUM_W'(mag_acc));
   assign est_sum  = neg_ff ? (est_ext - mag_s) : (est_ext + mag_s);
   assign est_over = !((&est_sum[SUM_W-1:DATA_WIDTH-1]) || (~|est_sum[SUM_W-1:DATA_WIDTH-1]));
   assign est_sat  = est_over ? (est_sum[SUM_W-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}})
                              : est_sum[DATA_WIDTH-1:0];

   // Rounded new covariance.
   assign p_round = (PROD_W + 1)'(mul_ff) + (PROD_W + 1)'(HALF_Q24);

   // Adapt direction: error magnitude strictly above 1.0.
   assign sample_cmp = CMP_W'(sample_ff);
   assign big_err    = (sample_cmp > THRESH_POS) || (sample_cmp < THRESH_NEG);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_LO: begin
            mul_a = NOISE_W'(mag_ext[GAIN_W-1:0]);
            mul_b = FACT_W'(gain_ff);
         end
         S_MUL_HI: begin
            mul_a = NOISE_W'(mag_ext[EXT_W-1:GAIN_W]);
            mul_b = FACT_W'(gain_ff);
         end
         S_MUL_P: begin
            mul_a = pp_ff;
            mul_b = GAIN_ONE - FACT_W'(gain_ff);
         end
         S_A_Q: begin
            mul_a = q_ff;
            mul_b = big_err ? UP_FACTOR : DOWN_FACTOR;
         end
         S_A_R: begin
            mul_a = r_ff;
            mul_b = big_err ? DOWN_FACTOR : UP_FACTOR;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Sequencer and next-state values.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cfg_q_in     = cfg_q_ff;
      cfg_r_in     = cfg_r_ff;
      estimate_in  = estimate_ff;
      cov_in       = cov_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      gain_in      = gain_ff;
      sample_in    = sample_ff;
      pp_in        = pp_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      corr_in      = corr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_Q_INIT: cfg_q_in = csr_data;
            CSR_R_INIT: cfg_r_in = csr_data;
            default:    cfg_q_in = cfg_q_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[DATA_WIDTH-1:0];
               unique case (req_tuser)
                  OP_UPDATE: state_in = S_PREP;
                  OP_ADAPT:  state_in = S_A_Q;
                  OP_REINIT: begin
                     estimate_in = '0;
                     cov_in      = '0;
                     gain_in     = '0;
                     q_in        = cfg_q_ff;
                     r_in        = cfg_r_ff;
                     state_in    = S_FIN;
                  end
                  default:   state_in = S_FIN;
               endcase
            end
         end
         S_PREP: begin
            pp_in  = pp_sat;
            den_in = den_sum;
            rem_in = {1'b0, pp_sat};
            mag_in = diff_mag;
            neg_in = diff[DATA_WIDTH];
            cnt_in = '0;
            if (den_sum == '0) begin
               // Nothing to weigh: gain clears, estimate and p stay.
               gain_in  = '0;
               state_in = S_FIN;
            end else if (r_ff == '0) begin
               // Gain would be exactly one.
               gain_in  = GAIN_MAX;
               state_in = S_MUL_LO;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = rem_ge ? rem_sub[NOISE_W:0] : rem_dbl[NOISE_W:0];
            gain_in = {gain_ff[GAIN_W-2:0], rem_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: begin
            corr_in  = lo_round[2*GAIN_W:GAIN_W];
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            estimate_in = est_sat;
            state_in    = S_P_WR;
         end
         S_P_WR: begin
            cov_in   = p_round[NOISE_W+GAIN_W-1:GAIN_W];
            state_in = S_FIN;
         end
         S_A_Q: state_in = S_A_R;
         S_A_R: begin
            q_in     = scale_noise(mul_ff);
            state_in = S_A_WR;
         end
         S_A_WR: begin
            r_in     = scale_noise(mul_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({r_ff, q_ff, gain_ff, estimate_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         cfg_q_ff     <= Q_RESET;
         cfg_r_ff     <= R_RESET;
         estimate_ff  <= '0;
         cov_ff       <= '0;
         q_ff         <= Q_RESET;
         r_ff         <= R_RESET;
         gain_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cfg_q_ff     <= cfg_q_in;
         cfg_r_ff     <= cfg_r_in;
         estimate_ff  <= estimate_in;
         cov_ff       <= cov_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      pp_ff       <= pp_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      corr_ff     <= corr_in;
      mul_ff      <= mul_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // When the divider runs, it finishes its full count before the multiply steps.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_LO && $past(state_ff) == S_DIV)
         |-> ($past(cnt_ff) == CNT_W'(DIV_STEPS - 1)))
      else $error("divider left before its last step");

   // Adapted noise values respect the floor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && $past(state_ff) == S_A_WR)
         |-> (q_ff >= NOISE_FLOOR && r_ff >= NOISE_FLOOR))
      else $error("adapted noise below floor");

   // An update never grows the covariance beyond the prediction.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_WR) |=> (cov_ff <= $past(pp_ff)))
      else $error("covariance grew on update");

   // A finished item with a free output register shows up on the response side.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) |=> (rsp_tvalid && req_tready))
      else $error("finished item not presented");

endmodule

/* verif/scalar_kalman_filter_adaptive_tb.sv */
`timescale 1ns / 100ps

module scalar_kalman_filter_adaptive_tb;
   import skfa_pkg::*;

   localparam int     DW           = 32;
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     RANDOM_WORDS = 500;
   localparam int     PRINT_LIMIT  = 30;
   localparam longint EST_MAX      = 2147483647;
   localparam longint EST_MIN      = -EST_MAX - 1;

   // Codes that the package leaves unnamed.
   localparam op_type        OP_UNUSED  = 2'd3;
   localparam csr_index_type CSR_SPARE0 = 2'd2;
   localparam csr_index_type CSR_SPARE1 = 2'd3;

   typedef struct {
      op_type      op;
      logic [31:0] sample;
   } filter_req_type;

   typedef struct {
      logic [31:0] estimate;
      gain_type    gain;
      noise_type   q;
      noise_type   r;
   } filter_rsp_type;

   logic           clock      = 1'b0;
   logic           reset      = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [DW-1:0]  req_tdata  = '0;
   op_type         req_tuser  = OP_UPDATE;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [119:0]   rsp_tdata;
   logic           csr_valid  = 1'b0;
   logic           csr_ready;
   csr_index_type  csr_index  = CSR_Q_INIT;
   noise_type      csr_data   = '0;

   // Words waiting to be sent and filter states waiting to come back.
   filter_req_type pending_words[$];
   filter_rsp_type predicted_states[$];
   filter_req_type next_word;
   filter_rsp_type seen_state;
   filter_rsp_type want_state;

   // Local copy of the filter state and of the configuration.
   longint    est_m;
   noise_type cov_m;
   noise_type q_m;
   noise_type r_m;
   gain_type  gain_m;
   noise_type cfg_q_m;
   noise_type cfg_r_m;

   bit req_taken     = 1'b0;
   bit hold_go       = 1'b0;
   int hold_count    = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int signal_level  = 0;
   int cycle_count   = 0;
   int error_count   = 0;
   int rsp_count     = 0;
   int csr_count     = 0;
   int op_count[4]   = '{0, 0, 0, 0};

   scalar_kalman_filter_adaptive #(
      .DATA_WIDTH(DW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // sample_value
      .req_tuser  (req_tuser),    // operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // estimate, gain, process_noise, measure_noise
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Scale a noise covariance by a Q1.24 factor, round, saturate and floor.
   function automatic noise_type scaled_noise(noise_type x, factor_type f);
      logic [63:0] v;
      v = (64'(x) * 64'(f) + 64'(HALF_Q24)) >> 24;
      if (v > 64'hFFFF_FFFF) begin
         v = 64'hFFFF_FFFF;
      end
      if (v < 64'(NOISE_FLOOR)) begin
         v = 64'(NOISE_FLOOR);
      end
      return v[31:0];
   endfunction

   // Advance the local filter by one word and return the state it reports.
   function automatic filter_rsp_type predict_filter_step(op_type op, logic [31:0] sample);
      logic [63:0]    pp;
      logic [63:0]    denom;
      logic [63:0]    g;
      logic [63:0]    mag;
      logic [63:0]    corr;
      longint         value;
      longint         diff;
      longint         next_est;
      filter_rsp_type s;
      value = longint'($signed(sample));
      case (op)
         OP_UPDATE: begin
            pp = 64'(cov_m) + 64'(q_m);
            if (pp > 64'hFFFF_FFFF) begin
               pp = 64'hFFFF_FFFF;
            end
            denom = pp + 64'(r_m);
            if (denom == 0) begin
               // Nothing to weigh against: only the gain is cleared.
               gain_m = '0;
            end else begin
               g = (pp << 24) / denom;
               if (g > 64'(GAIN_MAX)) begin
                  g = 64'(GAIN_MAX);
               end
               gain_m = g[23:0];
               diff   = value - est_m;
               mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
               // Split the product so that only the low part is rounded.
               corr   = (mag >> 24) * g + (((mag & 64'hFF_FFFF) * g + 64'(HALF_Q24)) >> 24);
               next_est = (diff < 0) ? est_m - longint'(corr) : est_m + longint'(corr);
               if (next_est > EST_MAX) begin
                  next_est = EST_MAX;
               end
               if (next_est < EST_MIN) begin
                  next_est = EST_MIN;
               end
               est_m = next_est;
               cov_m = 32'(((64'(GAIN_ONE) - g) * pp + 64'(HALF_Q24)) >> 24);
            end
         end
         OP_ADAPT: begin
            // An error of exactly one does not count as large.
            if (((value < 0) ? -value : value) > longint'(ONE_Q16)) begin
               q_m = scaled_noise(q_m, UP_FACTOR);
               r_m = scaled_noise(r_m, DOWN_FACTOR);
            end else begin
               q_m = scaled_noise(q_m, DOWN_FACTOR);
               r_m = scaled_noise(r_m, UP_FACTOR);
            end
         end
         OP_REINIT: begin
            est_m  = 0;
            cov_m  = '0;
            gain_m = '0;
            q_m    = cfg_q_m;
            r_m    = cfg_r_m;
         end
         default: begin
         end
      endcase
      s.estimate = est_m[31:0];
      s.gain     = gain_m;
      s.q        = q_m;
      s.r        = r_m;
      return s;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   task automatic queue_word(op_type op, logic [31:0] sample);
      filter_req_type w;
      w.op     = op;
      w.sample = sample;
      pending_words.push_back(w);
   endtask

   // Write one configuration register; the caller makes sure the block is idle.
   task automatic write_csr(csr_index_type idx, noise_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every word is sent and answered, then let the block settle.
   // The check runs a little after the falling edge, once the driver has updated.
   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (pending_words.size() != 0 || req_tvalid || predicted_states.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random word: mostly updates that track a drifting signal, adapts near the
   // threshold, a few reinits and unused codes, and some raw noise.
   function automatic filter_req_type random_word();
      filter_req_type w;
      int             pick;
      int             shape;
      int             offset;
      pick  = $urandom_range(99);
      shape = $urandom_range(9);
      if (pick < 62) begin
         w.op = OP_UPDATE;
      end else if (pick < 88) begin
         w.op = OP_ADAPT;
      end else if (pick < 94) begin
         w.op = OP_REINIT;
      end else begin
         w.op = OP_UNUSED;
      end
      w.sample = $urandom;
      if (shape >= 2 && w.op == OP_UPDATE) begin
         signal_level += int'($urandom_range(0, ONE_Q16 / 2)) - ONE_Q16 / 4;
         if (shape == 8) begin
            signal_level = int'($urandom_range(0, 200 * ONE_Q16)) - 100 * ONE_Q16;
         end
         offset = int'($urandom_range(0, 8 * ONE_Q16)) - 4 * ONE_Q16;
         w.sample = 32'(signal_level + offset);
         if (shape == 9) begin
            case ($urandom_range(3))
               0: w.sample = 32'h7FFF_FFFF;
               1: w.sample = 32'h8000_0000;
               2: w.sample = 32'h0000_0000;
               default: w.sample = 32'hFFFF_FFFF;
            endcase
         end
      end else if (shape >= 2 && w.op == OP_ADAPT) begin
         offset = (shape == 9) ? ONE_Q16 : int'($urandom_range(0, 2 * ONE_Q16));
         w.sample = ($urandom_range(1) != 0) ? 32'(-offset) : 32'(offset);
      end
      return w;
   endfunction

   // Clocked checks: configuration writes, returned words and accepted words.
   always @(posedge clock) begin
      cycle_count++;
      req_taken = 1'b0;
      if (reset) begin
         cfg_q_m = Q_RESET;
         cfg_r_m = R_RESET;
         est_m   = 0;
         cov_m   = '0;
         gain_m  = '0;
         q_m     = Q_RESET;
         r_m     = R_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_count++;
            if (csr_index == CSR_Q_INIT) begin
               cfg_q_m = csr_data;
            end else if (csr_index == CSR_R_INIT) begin
               cfg_r_m = csr_data;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_state.estimate = rsp_tdata[31:0];
            seen_state.gain     = rsp_tdata[55:32];
            seen_state.q        = rsp_tdata[87:56];
            seen_state.r        = rsp_tdata[119:88];
            if (predicted_states.size() == 0) begin
               report_mismatch($sformatf("response word with nothing expected, estimate %h",
                                         seen_state.estimate));
            end else begin
               want_state = predicted_states.pop_front();
               rsp_count++;
               if (seen_state.estimate !== want_state.estimate) begin
                  report_mismatch($sformatf("word %0d estimate %h, expected %h", rsp_count,
                                            seen_state.estimate, want_state.estimate));
               end
               if (seen_state.gain !== want_state.gain) begin
                  report_mismatch($sformatf("word %0d gain %h, expected %h", rsp_count,
                                            seen_state.gain, want_state.gain));
               end
               if (seen_state.q !== want_state.q) begin
                  report_mismatch($sformatf("word %0d process noise %h, expected %h", rsp_count,
                                            seen_state.q, want_state.q));
               end
               if (seen_state.r !== want_state.r) begin
                  report_mismatch($sformatf("word %0d measure noise %h, expected %h", rsp_count,
                                            seen_state.r, want_state.r));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted_states.push_back(predict_filter_step(req_tuser, req_tdata));
            op_count[req_tuser]++;
            req_taken = 1'b1;
         end
      end
   end

   // Request driver: holds a word until it is taken, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_word   = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_word.op;
            req_tdata  <= next_word.sample;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted once it is armed.
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_CYCLES) begin
         hold_count++;
      end
   end

   // Response ready with random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(hold_go && hold_count < HOLD_CYCLES) &&
                       ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Run watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[scalar_kalman_filter_adaptive] ERROR");
      $finish;
   end

   // Stimulus sequence.
   initial begin
      int send_pct[3];
      int recv_pct[3];
      send_pct = '{16, 46, 0};
      recv_pct = '{46, 16, 0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = send_pct[0];
      rsp_idle_pct = recv_pct[0];

      // Reset configuration: field extremes and the adapt threshold.
      queue_word(OP_UPDATE, 32'h0000_0000);
      queue_word(OP_UPDATE, 32'h7FFF_FFFF);
      queue_word(OP_UPDATE, 32'h8000_0000);
      queue_word(OP_UPDATE, 32'h0003_0000);
      queue_word(OP_ADAPT,  32'h0001_0000);
      queue_word(OP_ADAPT,  32'hFFFF_0000);
      queue_word(OP_ADAPT,  32'h0001_0001);
      queue_word(OP_ADAPT,  32'hFFFE_FFFF);
      queue_word(OP_ADAPT,  32'h8000_0000);
      queue_word(OP_ADAPT,  32'h7FFF_FFFF);
      queue_word(OP_UNUSED, 32'hFFFF_FFFF);
      queue_word(OP_REINIT, 32'h5A5A_5A5A);
      wait_idle();

      // All noise zero: zero denominator, then the floor after an adapt.
      write_csr(CSR_Q_INIT, 32'h0000_0000);
      write_csr(CSR_R_INIT, 32'h0000_0000);
      write_csr(CSR_SPARE0, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE1, 32'hFFFF_FFFF);
      @(posedge clock);
      queue_word(OP_REINIT, 32'h0000_0000);
      queue_word(OP_UPDATE, 32'h1234_5678);
      queue_word(OP_ADAPT,  32'h0000_0000);
      queue_word(OP_UPDATE, 32'hFFFF_0000);
      wait_idle();

      // Zero measurement noise: the gain saturates.
      write_csr(CSR_Q_INIT, 32'h0100_0000);
      write_csr(CSR_R_INIT, 32'h0000_0000);
      @(posedge clock);
      queue_word(OP_REINIT, 32'h0000_0000);
      queue_word(OP_UPDATE, 32'h7FFF_FFFF);
      queue_word(OP_UPDATE, 32'h8000_0000);
      wait_idle();

      // Largest noise: p+q and the scaled q saturate.
      write_csr(CSR_Q_INIT, 32'hFFFF_FFFF);
      write_csr(CSR_R_INIT, 32'hFFFF_FFFF);
      @(posedge clock);
      queue_word(OP_REINIT, 32'h0000_0000);
      queue_word(OP_ADAPT,  32'h0002_0000);
      queue_word(OP_UPDATE, 32'h4000_0000);
      queue_word(OP_UPDATE, 32'hC000_0000);
      wait_idle();

      // Register values under the floor load as written.
      write_csr(CSR_Q_INIT, 32'd5);
      write_csr(CSR_R_INIT, 32'd3);
      @(posedge clock);
      queue_word(OP_REINIT, 32'h0000_0000);
      queue_word(OP_UPDATE, 32'h0000_8000);
      queue_word(OP_ADAPT,  32'h0000_0001);

      // Random phases, one per idle profile, each with its own noise setting.
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_csr(CSR_Q_INIT, $urandom_range(17, 32'h0040_0000));
               write_csr(CSR_R_INIT, $urandom_range(32'h0001_0000, 32'h0400_0000));
            end
            1: begin
               write_csr(CSR_Q_INIT, $urandom);
               write_csr(CSR_R_INIT, $urandom);
            end
            default: begin
               write_csr(CSR_Q_INIT, NOISE_FLOOR);
               write_csr(CSR_R_INIT, $urandom_range(32'h0000_1000, 32'h1000_0000));
            end
         endcase
         @(posedge clock);
         req_idle_pct = send_pct[phase];
         rsp_idle_pct = recv_pct[phase];
         signal_level = 0;
         if (phase == 0) begin
            hold_go <= 1'b1;
         end
         queue_word(OP_REINIT, 32'h0000_0000);
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            pending_words.push_back(random_word());
         end
      end
      wait_idle();

      $display("Sent %0d request words (%0d updates, %0d adapts, %0d reinits, %0d unused)",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("with %0d register writes; %0d response words checked, %0d mismatches.",
               csr_count, rsp_count, error_count);
      if (error_count == 0) begin
         $display("[scalar_kalman_filter_adaptive] OK");
      end else begin
         $display("[scalar_kalman_filter_adaptive] ERROR");
      end
      $finish;
   end

endmodule
